// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define WNR_ASSERT_HOLDS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed")
`define WNR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed")
`else
`define WNR_ASSERT_HOLDS(lbl, expr)
`define WNR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/wnr_pkg.sv
// ----------------------------------------------------------------------------
// wnr_pkg
// Widths, defaults and controller/datapath command types for the resampler.
// ----------------------------------------------------------------------------
package wnr_pkg;

    localparam int DISPLAY_POINTS_DEF = 595;
    localparam int MAX_SAMPLES_DEF    = 4096;

    localparam int SAMPLE_W = 16;
    localparam int LIMIT_W  = 10;
    localparam int INDEX_W  = 10;
    localparam int VALUE_W  = 11;
    localparam int PEAK_W   = 17;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd173;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MEAN_DIV,
        OP_MEAN_TAKE,
        OP_PEAK_ADDR,
        OP_PEAK_ACC,
        OP_PEAK_SET,
        OP_READ_LATCH,
        OP_SRC_MUL,
        OP_SRC_DIV,
        OP_SRC_TAKE,
        OP_SRC_ADDR,
        OP_SCALE_MUL,
        OP_SCALE_DIV,
        OP_SCALE_TAKE,
        OP_RESULT_ZERO
    } op_t;

    typedef struct packed {
        op_t  op;
        logic div_start;
    } dp_cmd_t;

    typedef struct packed {
        logic closed;
        logic count_zero;
        logic count_one;
        logic x_zero;
        logic peak_last;
        logic div_done;
    } dp_status_t;

endpackage

// File: rtl/wnr_ram.sv
// ----------------------------------------------------------------------------
// wnr_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module wnr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                    clk,
    input  logic                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]        wdata,
    output logic [WIDTH-1:0]        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: rtl/wnr_div.sv
// ----------------------------------------------------------------------------
// wnr_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wnr_div #(
    parameter int DVW = 32,
    parameter int DSW = 17
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [DVW-1:0] dividend,
    input  logic [DSW-1:0] divisor,
    output logic           done,
    output logic [DVW-1:0] quotient
);

    localparam int CNTW = $clog2(DVW + 1);

    logic [DSW-1:0]  rem_reg;
    logic [DSW-1:0]  den_reg;
    logic [DVW-1:0]  quo_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            run_reg;
    logic            done_reg;
    logic [DSW:0]    rem_sh;
    logic            ge;
    logic [DSW-1:0]  rem_next;

    assign rem_sh   = {rem_reg, quo_reg[DVW-1]};
    assign ge       = (rem_sh >= {1'b0, den_reg});
    assign rem_next = ge ? DSW'(rem_sh - {1'b0, den_reg}) : DSW'(rem_sh);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNTW'(DVW);
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DVW-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/wnr_ctrl.sv
// ----------------------------------------------------------------------------
// wnr_ctrl
// Sequencer for sample loads, record close (mean, peak walk) and point reads.
// ----------------------------------------------------------------------------
module wnr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                cmd,
    input  logic                last,
    input  wnr_pkg::dp_status_t status,
    output logic                busy,
    output wnr_pkg::dp_cmd_t    dp_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MEAN_DIV,
        S_MEAN_WAIT,
        S_PEAK_ADDR,
        S_PEAK_ACC,
        S_PEAK_SET,
        S_DISPATCH,
        S_SRC_MUL,
        S_SRC_DIV,
        S_SRC_WAIT,
        S_SRC_ADDR,
        S_SCALE_MUL,
        S_SCALE_DIV,
        S_SCALE_WAIT
    } state_t;

    state_t        state_reg;
    state_t        state_next;
    logic          busy_reg;
    wnr_pkg::op_t  op;

    always_comb
    begin
        state_next = state_reg;
        op         = wnr_pkg::OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (cmd)
                    begin
                        op         = wnr_pkg::OP_READ_LATCH;
                        state_next = S_DISPATCH;
                    end
                    else
                    begin
                        op = wnr_pkg::OP_LOAD;
                        if (last)
                        begin
                            state_next = S_MEAN_DIV;
                        end
                    end
                end
            end
            S_MEAN_DIV:
            begin
                op         = wnr_pkg::OP_MEAN_DIV;
                state_next = S_MEAN_WAIT;
            end
            S_MEAN_WAIT:
            begin
                if (status.div_done)
                begin
                    op         = wnr_pkg::OP_MEAN_TAKE;
                    state_next = S_PEAK_ADDR;
                end
            end
            S_PEAK_ADDR:
            begin
                op         = wnr_pkg::OP_PEAK_ADDR;
                state_next = S_PEAK_ACC;
            end
            S_PEAK_ACC:
            begin
                op         = wnr_pkg::OP_PEAK_ACC;
                state_next = status.peak_last ? S_PEAK_SET : S_PEAK_ADDR;
            end
            S_PEAK_SET:
            begin
                op         = wnr_pkg::OP_PEAK_SET;
                state_next = S_IDLE;
            end
            S_DISPATCH:
            begin
                // Open or empty records, and the off-zero points of a
                // one-sample record, answer with a zero point.
                if (!status.closed || status.count_zero)
                begin
                    op         = wnr_pkg::OP_RESULT_ZERO;
                    state_next = S_IDLE;
                end
                else if (status.count_one)
                begin
                    if (status.x_zero)
                    begin
                        state_next = S_SRC_ADDR;
                    end
                    else
                    begin
                        op         = wnr_pkg::OP_RESULT_ZERO;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_SRC_MUL;
                end
            end
            S_SRC_MUL:
            begin
                op         = wnr_pkg::OP_SRC_MUL;
                state_next = S_SRC_DIV;
            end
            S_SRC_DIV:
            begin
                op         = wnr_pkg::OP_SRC_DIV;
                state_next = S_SRC_WAIT;
            end
            S_SRC_WAIT:
            begin
                op         = wnr_pkg::OP_SRC_TAKE;
                state_next = S_SRC_ADDR;
            end
            S_SRC_ADDR:
            begin
                op         = wnr_pkg::OP_SRC_ADDR;
                state_next = S_SCALE_MUL;
            end
            S_SCALE_MUL:
            begin
                op         = wnr_pkg::OP_SCALE_MUL;
                state_next = S_SCALE_DIV;
            end
            S_SCALE_DIV:
            begin
                op         = wnr_pkg::OP_SCALE_DIV;
                state_next = S_SCALE_WAIT;
            end
            S_SCALE_WAIT:
            begin
                if (status.div_done)
                begin
                    op         = wnr_pkg::OP_SCALE_TAKE;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy             = busy_reg;
    assign dp_cmd.op        = op;
    assign dp_cmd.div_start = (op == wnr_pkg::OP_MEAN_DIV) || (op == wnr_pkg::OP_SCALE_DIV);

endmodule

// File: rtl/wnr_dpath.sv
// ----------------------------------------------------------------------------
// wnr_dpath
// Sample store, record statistics, resampling and scaling arithmetic.
// ----------------------------------------------------------------------------
module wnr_dpath #(
    parameter int DISPLAY_POINTS = wnr_pkg::DISPLAY_POINTS_DEF,
    parameter int MAX_SAMPLES    = wnr_pkg::MAX_SAMPLES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  wnr_pkg::dp_cmd_t                     dp_cmd,
    output wnr_pkg::dp_status_t                  status,
    input  logic signed [wnr_pkg::SAMPLE_W-1:0]  sample,
    input  logic                                 last,
    input  logic [wnr_pkg::INDEX_W-1:0]          point_index,
    input  logic                                 cfg_we,
    input  logic [wnr_pkg::LIMIT_W-1:0]          cfg_wdata,
    output logic                                 result_valid,
    output logic signed [wnr_pkg::VALUE_W-1:0]   point_value,
    output logic                                 record_empty
);

    localparam int SMW  = wnr_pkg::SAMPLE_W;
    localparam int PKW  = wnr_pkg::PEAK_W;
    localparam int LMW  = wnr_pkg::LIMIT_W;
    localparam int IXW  = wnr_pkg::INDEX_W;
    localparam int VLW  = wnr_pkg::VALUE_W;
    localparam int CW   = $clog2(MAX_SAMPLES + 1);
    localparam int AW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int SW   = SMW + CW;
    localparam int PW   = $clog2(DISPLAY_POINTS);
    localparam int XW   = (PW > IXW) ? PW : IXW;
    localparam int SPW  = IXW + CW;
    localparam int MPW  = PKW + LMW;
    localparam int DVW  = (SW > MPW) ? SW : MPW;
    localparam int DSW  = (CW > PKW) ? CW : PKW;
    // The source index divides by the fixed point span with a rounded-up
    // reciprocal; the result is exact for every product below 2**SPW.
    localparam int RL   = $clog2(DISPLAY_POINTS - 1);
    localparam int RK   = SPW + RL;
    localparam int RMW  = SPW + 1;
    localparam int RQW  = SPW + RMW;
    localparam longint unsigned RECIP = ((64'd1 << RK) + 64'(DISPLAY_POINTS - 2))
                                        / 64'(DISPLAY_POINTS - 1);

    logic [CW-1:0]          count_reg;
    logic signed [SW-1:0]   sum_reg;
    logic                   closed_reg;
    logic signed [SMW-1:0]  mean_reg;
    logic [PKW-1:0]         peak_reg;
    logic [AW-1:0]          idx_reg;
    logic [IXW-1:0]         x_reg;
    logic [SPW-1:0]         src_prod_reg;
    logic [RQW-1:0]         src_q_reg;
    logic [AW-1:0]          src_reg;
    logic [MPW-1:0]         mag_reg;
    logic                   neg_reg;
    logic [LMW-1:0]         lim_reg;
    logic                   valid_reg;
    logic signed [VLW-1:0]  value_reg;
    logic                   empty_reg;

    logic [CW-1:0]          base_count;
    logic signed [SW-1:0]   base_sum;
    logic                   space;
    logic                   ram_we;
    logic [AW-1:0]          ram_addr;
    logic [SMW-1:0]         ram_rdata;
    logic signed [PKW-1:0]  dev;
    logic [PKW-1:0]         dev_abs;
    logic [SW-1:0]          sum_abs;
    logic [DVW-1:0]         div_dividend;
    logic [DSW-1:0]         div_divisor;
    logic                   div_done;
    logic [DVW-1:0]         div_quot;
    logic signed [PKW-1:0]  mean_wide;
    logic [IXW-1:0]         x_sat;
    logic [LMW-1:0]         clip;
    logic [CW-1:0]          count_m1;

    assign base_count = closed_reg ? '0 : count_reg;
    assign base_sum   = closed_reg ? '0 : sum_reg;
    assign space      = (base_count < CW'(MAX_SAMPLES));
    assign count_m1   = count_reg - CW'(1);

    assign ram_we = (dp_cmd.op == wnr_pkg::OP_LOAD) && space;

    always_comb
    begin
        case (dp_cmd.op)
            wnr_pkg::OP_LOAD:      ram_addr = base_count[AW-1:0];
            wnr_pkg::OP_PEAK_ADDR: ram_addr = idx_reg;
            default:               ram_addr = src_reg;
        endcase
    end

    wnr_ram #(
        .WIDTH (SMW),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (sample),
        .rdata (ram_rdata)
    );

    // Deviation of the stored word from the mean, shared by the peak walk
    // and the point scaling.
    assign dev     = PKW'($signed(ram_rdata)) - PKW'(mean_reg);
    assign dev_abs = dev[PKW-1] ? PKW'(-dev) : PKW'(dev);
    assign sum_abs = sum_reg[SW-1] ? SW'(-sum_reg) : SW'(sum_reg);

    assign x_sat = (XW'(point_index) > XW'(DISPLAY_POINTS - 1)) ?
                   IXW'(DISPLAY_POINTS - 1) : point_index;

    always_comb
    begin
        case (dp_cmd.op)
            wnr_pkg::OP_MEAN_DIV:
            begin
                div_dividend = DVW'(sum_abs);
                div_divisor  = DSW'(count_reg);
            end
            default:
            begin
                div_dividend = DVW'(mag_reg);
                div_divisor  = DSW'(peak_reg);
            end
        endcase
    end

    wnr_div #(
        .DVW (DVW),
        .DSW (DSW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dp_cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign mean_wide = sum_reg[SW-1] ? -$signed(PKW'(div_quot[PKW-1:0]))
                                     : $signed(PKW'(div_quot[PKW-1:0]));
    assign clip = (div_quot > DVW'(lim_reg)) ? lim_reg : LMW'(div_quot);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            sum_reg    <= '0;
            closed_reg <= 1'b0;
            mean_reg   <= '0;
            peak_reg   <= PKW'(1);
            lim_reg    <= wnr_pkg::LIMIT_RESET;
            valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                lim_reg <= cfg_wdata;
            end
            valid_reg <= (dp_cmd.op == wnr_pkg::OP_SCALE_TAKE)
                         || (dp_cmd.op == wnr_pkg::OP_RESULT_ZERO);
            case (dp_cmd.op)
                wnr_pkg::OP_LOAD:
                begin
                    count_reg  <= space ? base_count + CW'(1) : base_count;
                    sum_reg    <= space ? base_sum + SW'(sample) : base_sum;
                    closed_reg <= last;
                end
                wnr_pkg::OP_MEAN_TAKE:
                begin
                    mean_reg <= mean_wide[SMW-1:0];
                    peak_reg <= '0;
                end
                wnr_pkg::OP_PEAK_ACC:
                begin
                    if (dev_abs > peak_reg)
                    begin
                        peak_reg <= dev_abs;
                    end
                end
                wnr_pkg::OP_PEAK_SET:
                begin
                    if (peak_reg == '0)
                    begin
                        peak_reg <= PKW'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (dp_cmd.op)
            wnr_pkg::OP_MEAN_TAKE:
            begin
                idx_reg <= '0;
            end
            wnr_pkg::OP_PEAK_ACC:
            begin
                idx_reg <= idx_reg + AW'(1);
            end
            wnr_pkg::OP_READ_LATCH:
            begin
                x_reg   <= x_sat;
                src_reg <= '0;
            end
            wnr_pkg::OP_SRC_MUL:
            begin
                src_prod_reg <= SPW'(x_reg) * SPW'(count_m1);
            end
            wnr_pkg::OP_SRC_DIV:
            begin
                src_q_reg <= RQW'(src_prod_reg) * RQW'(RECIP);
            end
            wnr_pkg::OP_SRC_TAKE:
            begin
                src_reg <= AW'(src_q_reg >> RK);
            end
            wnr_pkg::OP_SCALE_MUL:
            begin
                neg_reg <= dev[PKW-1];
                mag_reg <= MPW'(dev_abs) * MPW'(lim_reg);
            end
            wnr_pkg::OP_SCALE_TAKE:
            begin
                value_reg <= neg_reg ? -$signed({1'b0, clip}) : $signed({1'b0, clip});
                empty_reg <= 1'b0;
            end
            wnr_pkg::OP_RESULT_ZERO:
            begin
                value_reg <= '0;
                empty_reg <= (count_reg == '0);
            end
            default:
            begin
            end
        endcase
    end

    assign status.closed     = closed_reg;
    assign status.count_zero = (count_reg == '0);
    assign status.count_one  = (count_reg == CW'(1));
    assign status.x_zero     = (x_reg == '0);
    assign status.peak_last  = (CW'(idx_reg) == count_m1);
    assign status.div_done   = div_done;

    assign result_valid = valid_reg;
    assign point_value  = value_reg;
    assign record_empty = empty_reg;

endmodule

// File: rtl/waveform_normalize_resample.sv
// ----------------------------------------------------------------------------
// waveform_normalize_resample
// Loads a sample record, then serves peak-normalized, resampled points.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. With cmd low it
// loads sample into the record; it produces no result and leaves busy low,
// so loads can arrive back to back. A load with last high closes the
// record: busy then stays high while the mean is divided out on the
// serial divider (one quotient bit per cycle) and the store is walked once
// for the peak deviation, each stored sample addressed, then accumulated.
// With cmd high a request reads one display point. The result appears for
// exactly one cycle with result_valid high; the receiver cannot hold it off.
// A zero point (open or empty record, or a nonzero point of a one-sample
// record) is answered straight from the dispatch state. Point zero of a
// one-sample record reads sample zero at once; any other point first takes
// a reciprocal multiply for the source index. Each then takes the scale
// multiply and one divider pass. busy is low again in the cycle the result
// appears. Reset empties the record, sets the amplitude limit to 173 and
// leaves the sample store contents unknown; no clearing pass is needed.
// The limit is written through cfg_we/cfg_wdata; the user must write it
// only while no request is in progress, as the block does not enforce it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module waveform_normalize_resample #(
    parameter int DISPLAY_POINTS = wnr_pkg::DISPLAY_POINTS_DEF,
    parameter int MAX_SAMPLES    = wnr_pkg::MAX_SAMPLES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 cmd,
    input  logic signed [wnr_pkg::SAMPLE_W-1:0]  sample,
    input  logic                                 last,
    input  logic [wnr_pkg::INDEX_W-1:0]          point_index,
    input  logic                                 cfg_we,
    input  logic [wnr_pkg::LIMIT_W-1:0]          cfg_wdata,
    output logic                                 result_valid,
    output logic signed [wnr_pkg::VALUE_W-1:0]   point_value,
    output logic                                 record_empty
);

    wnr_pkg::dp_cmd_t    dp_cmd;
    wnr_pkg::dp_status_t status;
    logic                go;

    assign go = start && !busy;

    wnr_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (go),
        .cmd    (cmd),
        .last   (last),
        .status (status),
        .busy   (busy),
        .dp_cmd (dp_cmd)
    );

    wnr_dpath #(
        .DISPLAY_POINTS (DISPLAY_POINTS),
        .MAX_SAMPLES    (MAX_SAMPLES)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .dp_cmd       (dp_cmd),
        .status       (status),
        .sample       (sample),
        .last         (last),
        .point_index  (point_index),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .result_valid (result_valid),
        .point_value  (point_value),
        .record_empty (record_empty)
    );

    `WNR_ASSERT_NEXT(a_single_strobe, result_valid, !result_valid);
    `WNR_ASSERT_NEXT(a_read_busy, go && cmd, busy);
    `WNR_ASSERT_NEXT(a_load_no_result, go && !cmd, !result_valid);
    `WNR_ASSERT_HOLDS(a_empty_zero, !(result_valid && record_empty) || (point_value == '0));

endmodule
